/* src/kfc_pkg.sv */
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants of the keypad calculator
// Key codes, pending operation codes, controller states and the request
// struct that passes between the controller and the serial arithmetic unit.
// ----------------------------------------------------------------------------
package kfc_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned OUT_WIDTH      = 32;
  localparam int unsigned FUNC_WIDTH     = 3;
  localparam int unsigned KEY_WIDTH      = 4;
  localparam int unsigned DEC_BASE       = 10;
  localparam int unsigned DIGIT_MAX      = 9;
  localparam int unsigned KEY_OP_MAX     = 3;

  // key kinds on func
  typedef enum logic [FUNC_WIDTH-1:0] {
    KEY_DIGIT = 3'd0,
    KEY_OPER  = 3'd1,
    KEY_CLEAR = 3'd2,
    KEY_BKSP  = 3'd3,
    KEY_ENTER = 3'd4
  } key_e;

  // pending operation
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  // what to do with the serial unit's result
  typedef enum logic [1:0] {
    FIN_DIGIT = 2'd0,
    FIN_BKSP  = 2'd1,
    FIN_ENTER = 2'd2
  } fin_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

endpackage

/* src/keypad_four_function_calculator.sv */
// ----------------------------------------------------------------------------
// keypad_four_function_calculator: four-function keypad calculator
// Takes one key event per transaction and returns the display after it.
// ----------------------------------------------------------------------------
// Each accepted key transaction returns exactly one output transaction with
// the display value (sign-extended from DATA_WIDTH to 32 bits, or its low 32
// bits for wider data). Clear, operator, enter with add or subtract, enter
// with nothing pending, division by zero, a digit that starts a new number and
// ignored keys finish without the serial unit. Appending a digit (display
// times ten plus the digit), backspace (divide by ten) and enter with
// multiply or divide go through a bit-serial multiply/divide unit that
// handles one bit per cycle, and no new key is taken until it is done.
// One key is processed at a time; a new key is taken as soon as the previous
// result has been taken or is being taken in the same cycle.
module keypad_four_function_calculator #(
  parameter int unsigned DATA_WIDTH = kfc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [kfc_pkg::FUNC_WIDTH-1:0]      func_i,
  input  logic [kfc_pkg::KEY_WIDTH-1:0]       key_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [kfc_pkg::OUT_WIDTH-1:0] display_value_o
);
  import kfc_pkg::*;

  // architectural state of the calculator
  logic [DATA_WIDTH-1:0] display_q, display_d;
  logic [DATA_WIDTH-1:0] first_q, first_d;
  op_e                   pending_q, pending_d;
  logic                  new_num_q, new_num_d;

  // control
  state_e                state_q, state_d;
  fin_e                  fin_q, fin_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;

  // serial unit hookup
  mdu_req_t              mdu_req;
  logic [DATA_WIDTH-1:0] mdu_a, mdu_b, mdu_addend;
  logic                  mdu_done;
  logic [DATA_WIDTH-1:0] mdu_result;

  // The display register only changes on an accepted key or at the end of a
  // serial operation, and a key is only accepted once the output slot is free,
  // so the display can drive the output directly and stays put while the result is stalled.
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    display_d   = display_q;
    first_d     = first_q;
    pending_d   = pending_q;
    new_num_d   = new_num_q;
    out_valid_d = out_valid_q && out_stall_i;
    mdu_req     = '0;
    mdu_a       = display_q;
    mdu_b       = DATA_WIDTH'(DEC_BASE);
    mdu_addend  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          case (key_e'(func_i))
            KEY_DIGIT: begin
              if (key_value_i <= KEY_WIDTH'(DIGIT_MAX)) begin
                if (new_num_q) begin
                  new_num_d = 1'b0;
                  display_d = DATA_WIDTH'(key_value_i);
                end else begin
                  // append: display * 10 + digit on the serial unit
                  mdu_req.start = 1'b1;
                  mdu_addend    = DATA_WIDTH'(key_value_i);
                  fin_d         = FIN_DIGIT;
                end
              end
            end
            KEY_OPER: begin
              if (key_value_i <= KEY_WIDTH'(KEY_OP_MAX)) begin
                pending_d = op_e'({1'b0, key_value_i[1:0]} + 3'd1);
                // a repeated operator only replaces the pending one
                if (!new_num_q) begin
                  new_num_d = 1'b1;
                  first_d   = display_q;
                end
              end
            end
            KEY_CLEAR: begin
              display_d = '0;
              new_num_d = 1'b1;
            end
            KEY_BKSP: begin
              // truncate toward zero: signed divide by ten
              mdu_req.start  = 1'b1;
              mdu_req.is_div = 1'b1;
              fin_d          = FIN_BKSP;
            end
            KEY_ENTER: begin
              mdu_a = first_q;
              mdu_b = display_q;
              case (pending_q)
                OP_ADD: begin
                  display_d = first_q + display_q;
                  first_d   = first_q + display_q;
                  pending_d = OP_NONE;
                  new_num_d = 1'b0;
                end
                OP_SUB: begin
                  display_d = first_q - display_q;
                  first_d   = first_q - display_q;
                  pending_d = OP_NONE;
                  new_num_d = 1'b0;
                end
                OP_MUL: begin
                  mdu_req.start = 1'b1;
                  fin_d         = FIN_ENTER;
                end
                OP_DIV: begin
                  if (display_q == '0) begin
                    // division by zero gives zero
                    display_d = '0;
                    first_d   = '0;
                    pending_d = OP_NONE;
                    new_num_d = 1'b0;
                  end else begin
                    mdu_req.start  = 1'b1;
                    mdu_req.is_div = 1'b1;
                    fin_d          = FIN_ENTER;
                  end
                end
                default: begin
                  // nothing pending: hold everything
                end
              endcase
            end
            default: begin
              // unused key kinds: drop
            end
          endcase
          if (mdu_req.start) begin
            out_valid_d = 1'b0;
            state_d     = ST_BUSY;
          end
        end
      end
      ST_BUSY: begin
        if (mdu_done) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          display_d   = mdu_result;
          case (fin_q)
            FIN_BKSP: begin
              new_num_d = (mdu_result == '0);
            end
            FIN_ENTER: begin
              first_d   = mdu_result;
              pending_d = OP_NONE;
              new_num_d = 1'b0;
            end
            default: begin
              // digit append leaves the new-number flag clear
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      display_q   <= '0;
      first_q     <= '0;
      pending_q   <= OP_NONE;
      new_num_q   <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      display_q   <= display_d;
      first_q     <= first_d;
      pending_q   <= pending_d;
      new_num_q   <= new_num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
  end

  kfc_mdu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mdu_req),
    .opa_i   (mdu_a),
    .opb_i   (mdu_b),
    .addend_i(mdu_addend),
    .done_o  (mdu_done),
    .result_o(mdu_result)
  );

  // widen by sign extension, or keep the low 32 bits
  generate
    if (DATA_WIDTH >= OUT_WIDTH) begin : g_out_trunc
      assign display_value_o = $signed(display_q[OUT_WIDTH-1:0]);
    end else begin : g_out_sext
      assign display_value_o =
          $signed({{(OUT_WIDTH - DATA_WIDTH){display_q[DATA_WIDTH-1]}}, display_q});
    end
  endgenerate

endmodule

/* src/kfc_mdu.sv */
// ----------------------------------------------------------------------------
// kfc_mdu: bit-serial multiply / signed divide unit
// Shift-add multiply (low DATA_WIDTH bits, plus an addend) and restoring
// signed division truncating toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module kfc_mdu #(
  parameter int unsigned DATA_WIDTH = kfc_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kfc_pkg::mdu_req_t     req_i,
  input  logic [DATA_WIDTH-1:0] opa_i,
  input  logic [DATA_WIDTH-1:0] opb_i,
  input  logic [DATA_WIDTH-1:0] addend_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);
  import kfc_pkg::*;

  localparam int unsigned CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic                  div_q, div_d;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;  // product / remainder
  logic [DATA_WIDTH-1:0] opb_q, opb_d;  // multiplicand / divisor
  logic [DATA_WIDTH-1:0] sh_q, sh_d;    // multiplier / dividend-quotient
  logic [DATA_WIDTH-1:0] a_mag, b_mag;
  logic [DATA_WIDTH:0]   trial;

  assign a_mag = opa_i[DATA_WIDTH-1] ? (~opa_i + 1'b1) : opa_i;
  assign b_mag = opb_i[DATA_WIDTH-1] ? (~opb_i + 1'b1) : opb_i;
  assign trial = {acc_q, sh_q[DATA_WIDTH-1]} - {1'b0, opb_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    div_d  = div_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opb_d  = opb_q;
    sh_d   = sh_q;
    if (req_i.start) begin
      run_d = 1'b1;
      div_d = req_i.is_div;
      cnt_d = CNT_W'(DATA_WIDTH - 1);
      if (req_i.is_div) begin
        acc_d = '0;
        opb_d = b_mag;
        sh_d  = a_mag;
        neg_d = opa_i[DATA_WIDTH-1] ^ opb_i[DATA_WIDTH-1];
      end else begin
        acc_d = addend_i;
        opb_d = opa_i;
        sh_d  = opb_i;
        neg_d = 1'b0;
      end
    end else if (run_q) begin
      if (div_q) begin
        // restore when the trial subtraction goes negative
        if (!trial[DATA_WIDTH]) begin
          acc_d = trial[DATA_WIDTH-1:0];
        end else begin
          acc_d = {acc_q[DATA_WIDTH-2:0], sh_q[DATA_WIDTH-1]};
        end
        sh_d = {sh_q[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
      end else begin
        if (sh_q[0]) begin
          acc_d = acc_q + opb_q;
        end
        opb_d = {opb_q[DATA_WIDTH-2:0], 1'b0};
        sh_d  = {1'b0, sh_q[DATA_WIDTH-1:1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    opb_q <= opb_d;
    sh_q  <= sh_d;
  end

  assign done_o   = done_q;
  assign result_o = !div_q ? acc_q : (neg_q ? (~sh_q + 1'b1) : sh_q);

endmodule
